// File: rtl/bvq_pkg.sv
// shared types and constants of the bounding volume query unit
`timescale 1ns / 1ps
`default_nettype none
package bvq_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int DIST_WIDTH = 64;
   localparam int REQ_TYPE_WIDTH = 2;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int NUM_STAGES = 6;

   typedef enum logic [REQ_TYPE_WIDTH-1:0] {
      REQ_OVERLAP  = 2'd0,
      REQ_ENCLOSES = 2'd1,
      REQ_ENCLOSED = 2'd2
   } req_code_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SELF_CENTER_X = 3'd0,
      CSR_SELF_CENTER_Y = 3'd1,
      CSR_SELF_CENTER_Z = 3'd2,
      CSR_SELF_HALF_X   = 3'd3,
      CSR_SELF_HALF_Y   = 3'd4,
      CSR_SELF_HALF_Z   = 3'd5
   } csr_index_type;

   // per transaction verdicts carried alongside the distance path
   typedef struct packed {
      logic [REQ_TYPE_WIDTH-1:0] req_type;
      logic                      sphere;
      logic                      encl;
      logic                      encd;
      logic                      box_ovl;
   } flags_type;

endpackage
`default_nettype wire

// File: rtl/bvq_setup.sv
// bounds, containment and box overlap tests, per axis clamp distance
`timescale 1ns / 1ps
`default_nettype none
module bvq_setup #(
   parameter int COORD_WIDTH = bvq_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic [1:0]                         load,
   input  logic [COORD_WIDTH-1:0]             self_center [3],
   input  logic [COORD_WIDTH-2:0]             self_half [3],
   input  logic [bvq_pkg::REQ_TYPE_WIDTH-1:0] req_type,
   input  logic                               other_is_sphere,
   input  logic [COORD_WIDTH-1:0]             other_center [3],
   input  logic [COORD_WIDTH-2:0]             other_half [3],
   input  logic [COORD_WIDTH-2:0]             other_radius,
   output logic [COORD_WIDTH-1:0]             dist_axis [3],
   output logic [COORD_WIDTH-2:0]             radius,
   output bvq_pkg::flags_type                 flags
);
   import bvq_pkg::*;

   localparam int W = COORD_WIDTH;

   // stage 1: corners one bit wider than the centers so nothing wraps
   logic signed [W:0]   sc_ext [3];
   logic signed [W:0]   oc_ext [3];
   logic signed [W:0]   sh_ext [3];
   logic signed [W:0]   oh_ext [3];
   logic [W-2:0]        oh_sel [3];
   logic signed [W:0]   smin_in [3];
   logic signed [W:0]   smax_in [3];
   logic signed [W:0]   omin_in [3];
   logic signed [W:0]   omax_in [3];
   logic signed [W:0]   gap_in [3];
   logic [W-1:0]        hsum_in [3];

   logic signed [W:0]   smin_ff [3];
   logic signed [W:0]   smax_ff [3];
   logic signed [W:0]   omin_ff [3];
   logic signed [W:0]   omax_ff [3];
   logic signed [W:0]   gap_ff [3];
   logic signed [W:0]   oc_ff [3];
   logic [W-1:0]        hsum_ff [3];
   logic [W-2:0]        r1_ff;
   logic [REQ_TYPE_WIDTH-1:0] req1_ff;
   logic                sphere1_ff;

   // stage 2
   logic [W:0]          gap_abs [3];
   logic signed [W:0]   lo_diff [3];
   logic signed [W:0]   hi_diff [3];
   logic [W-1:0]        dist_in [3];
   logic [2:0]          encl_axis;
   logic [2:0]          encd_axis;
   logic [2:0]          ovl_axis;
   flags_type           flags_in;

   logic [W-1:0]        dist_ff [3];
   logic [W-2:0]        r2_ff;
   flags_type           flags_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         oh_sel[i]  = other_is_sphere ? other_radius : other_half[i];
         sc_ext[i]  = signed'({self_center[i][W-1], self_center[i]});
         oc_ext[i]  = signed'({other_center[i][W-1], other_center[i]});
         sh_ext[i]  = signed'({2'b00, self_half[i]});
         oh_ext[i]  = signed'({2'b00, oh_sel[i]});
         smin_in[i] = sc_ext[i] - sh_ext[i];
         smax_in[i] = sc_ext[i] + sh_ext[i];
         omin_in[i] = oc_ext[i] - oh_ext[i];
         omax_in[i] = oc_ext[i] + oh_ext[i];
         gap_in[i]  = sc_ext[i] - oc_ext[i];
         hsum_in[i] = {1'b0, self_half[i]} + {1'b0, oh_sel[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         smin_ff    <= smin_in;
         smax_ff    <= smax_in;
         omin_ff    <= omin_in;
         omax_ff    <= omax_in;
         gap_ff     <= gap_in;
         oc_ff      <= oc_ext;
         hsum_ff    <= hsum_in;
         r1_ff      <= other_radius;
         req1_ff    <= req_type;
         sphere1_ff <= other_is_sphere;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         encl_axis[i] = !((omin_ff[i] < smin_ff[i]) || (omax_ff[i] > smax_ff[i]));
         encd_axis[i] = !((omin_ff[i] > smin_ff[i]) || (omax_ff[i] < smax_ff[i]));
         gap_abs[i]   = gap_ff[i][W] ? (~gap_ff[i] + 1'b1) : gap_ff[i];
         ovl_axis[i]  = gap_abs[i] <= {1'b0, hsum_ff[i]};
         lo_diff[i]   = smin_ff[i] - oc_ff[i];
         hi_diff[i]   = oc_ff[i] - smax_ff[i];
         // distance from the center to the slab, zero inside it
         if (oc_ff[i] < smin_ff[i]) begin
            dist_in[i] = lo_diff[i][W-1:0];
         end else if (oc_ff[i] > smax_ff[i]) begin
            dist_in[i] = hi_diff[i][W-1:0];
         end else begin
            dist_in[i] = '0;
         end
      end
      flags_in.req_type = req1_ff;
      flags_in.sphere   = sphere1_ff;
      flags_in.encl     = &encl_axis;
      flags_in.encd     = &encd_axis;
      flags_in.box_ovl  = &ovl_axis;
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         dist_ff  <= dist_in;
         r2_ff    <= r1_ff;
         flags_ff <= flags_in;
      end
   end

   assign dist_axis = dist_ff;
   assign radius    = r2_ff;
   assign flags     = flags_ff;

endmodule
`default_nettype wire

// File: rtl/bvq_square.sv
// two stage squarer built from half width partial products
`timescale 1ns / 1ps
`default_nettype none
module bvq_square #(
   parameter int DW = bvq_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic            clock,
   input  logic [1:0]      load,
   input  logic [DW-1:0]   value,
   output logic [2*DW-1:0] square
);
   import bvq_pkg::*;

   localparam int LO_W = (DW + 1) / 2;
   localparam int HI_W = DW - LO_W;

   logic [HI_W-1:0]      a;
   logic [LO_W-1:0]      b;
   logic [2*HI_W-1:0]    aa_in, aa_ff;
   logic [HI_W+LO_W-1:0] ab_in, ab_ff;
   logic [2*LO_W-1:0]    bb_in, bb_ff;
   logic [2*DW-1:0]      sq_in, sq_ff;

   assign a     = value[DW-1:LO_W];
   assign b     = value[LO_W-1:0];
   assign aa_in = a * a;
   assign ab_in = a * b;
   assign bb_in = b * b;

   always_ff @(posedge clock) begin
      if (load[0]) begin
         aa_ff <= aa_in;
         ab_ff <= ab_in;
         bb_ff <= bb_in;
      end
   end

   // (a*2^L + b)^2 = a^2*2^2L + 2ab*2^L + b^2
   assign sq_in = (2*DW)'({aa_ff, {(2*LO_W){1'b0}}})
                + (2*DW)'({ab_ff, {(LO_W+1){1'b0}}})
                + (2*DW)'(bb_ff);

   always_ff @(posedge clock) begin
      if (load[1]) begin
         sq_ff <= sq_in;
      end
   end

   assign square = sq_ff;

endmodule
`default_nettype wire

// File: rtl/bvq_finish.sv
// distance sum, sphere compare, saturation and answer select
`timescale 1ns / 1ps
`default_nettype none
module bvq_finish #(
   parameter int COORD_WIDTH = bvq_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic [1:0]                     load,
   input  logic [2*COORD_WIDTH-1:0]       axis_sq [3],
   input  logic [2*COORD_WIDTH-1:0]       radius_sq,
   input  bvq_pkg::flags_type             flags,
   output logic                           answer,
   output logic [bvq_pkg::DIST_WIDTH-1:0] sq_distance
);
   import bvq_pkg::*;

   localparam int SQ_W  = 2 * COORD_WIDTH;
   localparam int SUM_W = SQ_W + 2;
   localparam int EXT_W = (SUM_W > DIST_WIDTH) ? SUM_W : DIST_WIDTH;

   logic [SUM_W-1:0]      dsum_in, dsum_ff;
   logic [SQ_W-1:0]       rsq_ff;
   flags_type             flags_ff;
   logic [EXT_W-1:0]      sum_ext;
   logic                  sat;
   logic                  ovl;
   logic                  answer_in, answer_ff;
   logic [DIST_WIDTH-1:0] dist_in, dist_ff;

   assign dsum_in = SUM_W'(axis_sq[0]) + SUM_W'(axis_sq[1]) + SUM_W'(axis_sq[2]);

   always_ff @(posedge clock) begin
      if (load[0]) begin
         dsum_ff  <= dsum_in;
         rsq_ff   <= radius_sq;
         flags_ff <= flags;
      end
   end

   always_comb begin
      sum_ext = EXT_W'(dsum_ff);
      sat     = (sum_ext >> DIST_WIDTH) != '0;
      // exact compare, touching counts
      if (flags_ff.sphere) begin
         ovl     = dsum_ff <= SUM_W'(rsq_ff);
         dist_in = sat ? '1 : sum_ext[DIST_WIDTH-1:0];
      end else begin
         ovl     = flags_ff.box_ovl;
         dist_in = '0;
      end
      unique case (flags_ff.req_type)
         REQ_OVERLAP:  answer_in = ovl;
         REQ_ENCLOSES: answer_in = flags_ff.encl;
         REQ_ENCLOSED: answer_in = flags_ff.encd;
         default:      answer_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         answer_ff <= answer_in;
         dist_ff   <= dist_in;
      end
   end

   assign answer      = answer_ff;
   assign sq_distance = dist_ff;

endmodule
`default_nettype wire

// File: rtl/bounding_volume_query_unit.sv
// top level of the bounding volume query unit
//
//  channel | handshake                | payload
//  --------+--------------------------+-----------------------------------------
//  req     | req_valid / req_ready    | type, sphere flag, center, halves, radius
//  rsp     | rsp_valid / rsp_ready    | answer, squared sphere distance
//  csr     | csr_write_en             | csr_index, csr_wdata (no read-back)
//
// one transaction per cycle sustained through six register stages while rsp_ready stays high
// rsp_valid rises once the transaction reaches the sixth stage; the box tests, the two
// stage partial product squarer and the distance sum set that depth
// synchronous active high reset clears the stage valid bits and the box registers
// each stage holds its transaction while the next is full; bubbles are squeezed out
// so req_ready drops only when all six stages are full and rsp_ready is low
`timescale 1ns / 1ps
`default_nettype none
module bounding_volume_query_unit #(
   parameter int COORD_WIDTH = bvq_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bvq_pkg::REQ_TYPE_WIDTH-1:0]  req_type,
   input  logic                                req_other_is_sphere,
   input  logic [COORD_WIDTH-1:0]              req_other_center_x,
   input  logic [COORD_WIDTH-1:0]              req_other_center_y,
   input  logic [COORD_WIDTH-1:0]              req_other_center_z,
   input  logic [COORD_WIDTH-2:0]              req_other_half_x,
   input  logic [COORD_WIDTH-2:0]              req_other_half_y,
   input  logic [COORD_WIDTH-2:0]              req_other_half_z,
   input  logic [COORD_WIDTH-2:0]              req_other_radius,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_answer,
   output logic [bvq_pkg::DIST_WIDTH-1:0]      rsp_sphere_sq_distance,
   // register write port
   input  logic                                csr_write_en,
   input  logic [bvq_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]              csr_wdata
);
   import bvq_pkg::*;

   localparam int W    = COORD_WIDTH;
   localparam int LAST = NUM_STAGES - 1;

   // box registers
   logic [W-1:0] self_center_ff [3];
   logic [W-2:0] self_half_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            self_center_ff[i] <= '0;
            self_half_ff[i]   <= '0;
         end
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SELF_CENTER_X: self_center_ff[0] <= csr_wdata;
            CSR_SELF_CENTER_Y: self_center_ff[1] <= csr_wdata;
            CSR_SELF_CENTER_Z: self_center_ff[2] <= csr_wdata;
            CSR_SELF_HALF_X:   self_half_ff[0]   <= csr_wdata[W-2:0];
            CSR_SELF_HALF_Y:   self_half_ff[1]   <= csr_wdata[W-2:0];
            CSR_SELF_HALF_Z:   self_half_ff[2]   <= csr_wdata[W-2:0];
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   // stage valid bits and back-to-front ready chain
   logic [NUM_STAGES-1:0] v_ff, v_in;
   logic [NUM_STAGES-1:0] stage_ready;
   logic [NUM_STAGES-1:0] load_stage;
   logic                  in_acc;
   logic                  out_acc;

   always_comb begin
      stage_ready[LAST] = !v_ff[LAST] || rsp_ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         stage_ready[k] = !v_ff[k] || stage_ready[k+1];
      end
      load_stage[0] = stage_ready[0] && req_valid;
      v_in[0]       = stage_ready[0] ? req_valid : v_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         load_stage[k] = stage_ready[k] && v_ff[k-1];
         v_in[k]       = stage_ready[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = stage_ready[0];
   assign rsp_valid = v_ff[LAST];
   assign in_acc    = req_valid && req_ready;
   assign out_acc   = rsp_valid && rsp_ready;

   // stages 1-2: corners, box tests, clamp distances
   logic [W-1:0] other_center [3];
   logic [W-2:0] other_half [3];
   logic [W-1:0] dist_axis [3];
   logic [W-2:0] radius2;
   flags_type    flags2;

   assign other_center[0] = req_other_center_x;
   assign other_center[1] = req_other_center_y;
   assign other_center[2] = req_other_center_z;
   assign other_half[0]   = req_other_half_x;
   assign other_half[1]   = req_other_half_y;
   assign other_half[2]   = req_other_half_z;

   bvq_setup #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_setup (
      .clock           (clock),
      .load            (load_stage[1:0]),
      .self_center     (self_center_ff),
      .self_half       (self_half_ff),
      .req_type        (req_type),
      .other_is_sphere (req_other_is_sphere),
      .other_center    (other_center),
      .other_half      (other_half),
      .other_radius    (req_other_radius),
      .dist_axis       (dist_axis),
      .radius          (radius2),
      .flags           (flags2)
   );

   // stages 3-4: squares of the three distances and the radius
   logic [2*W-1:0] axis_sq [3];
   logic [2*W-1:0] radius_sq;

   for (genvar g = 0; g < 3; g++) begin : g_axis_sq
      bvq_square #(
         .DW (W)
      ) u_square (
         .clock  (clock),
         .load   (load_stage[3:2]),
         .value  (dist_axis[g]),
         .square (axis_sq[g])
      );
   end

   bvq_square #(
      .DW (W)
   ) u_radius_sq (
      .clock  (clock),
      .load   (load_stage[3:2]),
      .value  ({1'b0, radius2}),
      .square (radius_sq)
   );

   // verdict flags ride along with the squarer stages
   flags_type flags3_ff;
   flags_type flags4_ff;

   always_ff @(posedge clock) begin
      if (load_stage[2]) begin
         flags3_ff <= flags2;
      end
      if (load_stage[3]) begin
         flags4_ff <= flags3_ff;
      end
   end

   // stages 5-6: sum, compare, saturate, output register
   bvq_finish #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_finish (
      .clock       (clock),
      .load        (load_stage[5:4]),
      .axis_sq     (axis_sq),
      .radius_sq   (radius_sq),
      .flags       (flags4_ff),
      .answer      (rsp_answer),
      .sq_distance (rsp_sphere_sq_distance)
   );

   // a stalled stage never loses its transaction
   for (genvar g = 0; g < LAST; g++) begin : g_hold_check
      a_stage_hold : assert property (@(posedge clock) disable iff (reset)
         (v_ff[g] && !stage_ready[g+1]) |=> v_ff[g])
         else $error("stage %0d dropped a stalled transaction", g);
   end

   // occupancy follows accepted requests minus delivered responses
   a_occupancy : assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(v_ff) == $past($countones(v_ff))
                + int'($past(in_acc)) - int'($past(out_acc))))
      else $error("pipeline occupancy out of step with handshakes");

   // reset empties the pipeline
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> (v_ff == '0))
      else $error("stage valid bits set after reset");

endmodule
`default_nettype wire

// File: test/bvq_checker.sv
// transaction checker for the bounding volume query unit: predicts each answer and compares
`timescale 1ns / 1ps
module bvq_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [bvq_pkg::REQ_TYPE_WIDTH-1:0]  req_type,
   input  logic                                req_other_is_sphere,
   input  logic [31:0]                         req_other_center_x,
   input  logic [31:0]                         req_other_center_y,
   input  logic [31:0]                         req_other_center_z,
   input  logic [30:0]                         req_other_half_x,
   input  logic [30:0]                         req_other_half_y,
   input  logic [30:0]                         req_other_half_z,
   input  logic [30:0]                         req_other_radius,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                rsp_answer,
   input  logic [bvq_pkg::DIST_WIDTH-1:0]      rsp_sphere_sq_distance,
   input  logic                                csr_write_en,
   input  logic [bvq_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                         csr_wdata,
   output int                                  failures,
   output int                                  pending,
   output int                                  checked,
   output int                                  true_answers,
   output int                                  saturated
);
   import bvq_pkg::*;

   localparam int ACC_W = 72;

   typedef struct packed {
      logic                  answer;
      logic [DIST_WIDTH-1:0] sq_distance;
   } query_verdict_type;

   query_verdict_type awaited_verdicts[$];
   longint box_c [3];
   longint box_h [3];

   function automatic query_verdict_type judge_query(
      input logic [REQ_TYPE_WIDTH-1:0] kind,
      input logic                      is_sphere,
      input logic [31:0]               ocx, ocy, ocz,
      input logic [30:0]               ohx, ohy, ohz, orad
   );
      longint q_c [3];
      longint q_h [3];
      longint lo_s, hi_s, lo_q, hi_q, gap;
      logic [ACC_W-1:0] d, dist_acc, rad_sq;
      logic overlap, encl, encd;
      query_verdict_type res;
      q_c[0] = longint'($signed(ocx));
      q_c[1] = longint'($signed(ocy));
      q_c[2] = longint'($signed(ocz));
      q_h[0] = is_sphere ? longint'(orad) : longint'(ohx);
      q_h[1] = is_sphere ? longint'(orad) : longint'(ohy);
      q_h[2] = is_sphere ? longint'(orad) : longint'(ohz);
      dist_acc = '0;
      overlap = 1'b1;
      encl = 1'b1;
      encd = 1'b1;
      for (int i = 0; i < 3; i++) begin
         lo_s = box_c[i] - box_h[i];
         hi_s = box_c[i] + box_h[i];
         lo_q = q_c[i] - q_h[i];
         hi_q = q_c[i] + q_h[i];
         if (lo_q < lo_s || hi_q > hi_s) encl = 1'b0;
         if (lo_q > lo_s || hi_q < hi_s) encd = 1'b0;
         if (is_sphere) begin
            d = '0;
            if (q_c[i] < lo_s) d = ACC_W'(lo_s - q_c[i]);
            else if (q_c[i] > hi_s) d = ACC_W'(q_c[i] - hi_s);
            dist_acc = dist_acc + d * d;
         end else begin
            gap = box_c[i] - q_c[i];
            if (gap < 0) gap = -gap;
            if (gap > box_h[i] + q_h[i]) overlap = 1'b0;
         end
      end
      if (is_sphere) begin
         rad_sq = ACC_W'(q_h[0]) * ACC_W'(q_h[0]);
         // touching the box surface still counts, compared before saturation
         overlap = (dist_acc <= rad_sq);
         res.sq_distance = (|dist_acc[ACC_W-1:DIST_WIDTH]) ? '1 : dist_acc[DIST_WIDTH-1:0];
      end else begin
         res.sq_distance = '0;
      end
      case (kind)
         REQ_OVERLAP:  res.answer = overlap;
         REQ_ENCLOSES: res.answer = encl;
         REQ_ENCLOSED: res.answer = encd;
         default:      res.answer = 1'b0;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : watch
      query_verdict_type oldest;
      if (reset) begin
         awaited_verdicts.delete();
         for (int i = 0; i < 3; i++) begin
            box_c[i] = 0;
            box_h[i] = 0;
         end
         failures = 0;
         checked = 0;
         true_answers = 0;
         saturated = 0;
      end else begin
         // results first, so a transaction entering on this edge cannot hide a stray result
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (rsp_answer) true_answers++;
            if (&rsp_sphere_sq_distance) saturated++;
            if (awaited_verdicts.size() == 0) begin
               failures++;
               $error("unexpected result: rsp_answer %0d rsp_sphere_sq_distance %0h",
                      rsp_answer, rsp_sphere_sq_distance);
            end else begin
               oldest = awaited_verdicts.pop_front();
               if (rsp_answer !== oldest.answer) begin
                  failures++;
                  $error("rsp_answer expected %0d actual %0d", oldest.answer, rsp_answer);
               end
               if (rsp_sphere_sq_distance !== oldest.sq_distance) begin
                  failures++;
                  $error("rsp_sphere_sq_distance expected %0h actual %0h",
                         oldest.sq_distance, rsp_sphere_sq_distance);
               end
            end
         end
         if (req_valid && req_ready)
            awaited_verdicts.insert(awaited_verdicts.size(),
               judge_query(req_type, req_other_is_sphere,
               req_other_center_x, req_other_center_y, req_other_center_z,
               req_other_half_x, req_other_half_y, req_other_half_z, req_other_radius));
         if (csr_write_en) begin
            case (csr_index)
               CSR_SELF_CENTER_X: box_c[0] = longint'($signed(csr_wdata));
               CSR_SELF_CENTER_Y: box_c[1] = longint'($signed(csr_wdata));
               CSR_SELF_CENTER_Z: box_c[2] = longint'($signed(csr_wdata));
               CSR_SELF_HALF_X:   box_h[0] = longint'(csr_wdata[30:0]);
               CSR_SELF_HALF_Y:   box_h[1] = longint'(csr_wdata[30:0]);
               CSR_SELF_HALF_Z:   box_h[2] = longint'(csr_wdata[30:0]);
               default: ;
            endcase
         end
      end
      pending = awaited_verdicts.size();
   end

endmodule

// File: test/tb.sv
// testbench top for the bounding volume query unit: stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb;
   import bvq_pkg::*;

   // request code the block leaves unused, answer must come back zero
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_SPARE = 2'd3;
   // register indexes past the six box registers, writes there are dropped
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_HI = 3'd7;

   localparam longint ONE      = 64'sd65536;          // 1.0 in Q16.16
   localparam longint MAXC     = 64'sh0000_0000_7FFF_FFFF;
   localparam longint MINC     = -64'sh0000_0000_8000_0000;
   localparam longint HALF_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint SPAN_MAX = 64'sh0000_0000_FFFF_FFFF;
   localparam int RANDOM_PHASES    = 6;
   localparam int RANDOM_PER_PHASE = 155;

   typedef struct packed {
      logic [REQ_TYPE_WIDTH-1:0] kind;
      logic                      sphere;
      logic [31:0]               cx, cy, cz;
      logic [30:0]               hx, hy, hz;
      logic [30:0]               radius;
   } query_item_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [REQ_TYPE_WIDTH-1:0]  req_type;
   logic                       req_other_is_sphere;
   logic [31:0]                req_other_center_x;
   logic [31:0]                req_other_center_y;
   logic [31:0]                req_other_center_z;
   logic [30:0]                req_other_half_x;
   logic [30:0]                req_other_half_y;
   logic [30:0]                req_other_half_z;
   logic [30:0]                req_other_radius;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic                       rsp_answer;
   logic [DIST_WIDTH-1:0]      rsp_sphere_sq_distance;
   logic                       csr_write_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [31:0]                csr_wdata;

   int failures, pending, checked, true_answers, saturated;

   // copy of the programmed box, only used to aim the random queries
   longint box_c [3];
   longint box_h [3];

   // idling knobs, percent per transaction (sender) and per cycle (receiver)
   int gap_pct;
   int stall_pct;

   int sent_sphere, sent_box, sent_spare, settings;

   bounding_volume_query_unit dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_type               (req_type),
      .req_other_is_sphere    (req_other_is_sphere),
      .req_other_center_x     (req_other_center_x),
      .req_other_center_y     (req_other_center_y),
      .req_other_center_z     (req_other_center_z),
      .req_other_half_x       (req_other_half_x),
      .req_other_half_y       (req_other_half_y),
      .req_other_half_z       (req_other_half_z),
      .req_other_radius       (req_other_radius),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_answer             (rsp_answer),
      .rsp_sphere_sq_distance (rsp_sphere_sq_distance),
      .csr_write_en           (csr_write_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   bvq_checker watcher (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_type               (req_type),
      .req_other_is_sphere    (req_other_is_sphere),
      .req_other_center_x     (req_other_center_x),
      .req_other_center_y     (req_other_center_y),
      .req_other_center_z     (req_other_center_z),
      .req_other_half_x       (req_other_half_x),
      .req_other_half_y       (req_other_half_y),
      .req_other_half_z       (req_other_half_z),
      .req_other_radius       (req_other_radius),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_answer             (rsp_answer),
      .rsp_sphere_sq_distance (rsp_sphere_sq_distance),
      .csr_write_en           (csr_write_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .failures               (failures),
      .pending                (pending),
      .checked                (checked),
      .true_answers           (true_answers),
      .saturated              (saturated)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs or loses a transaction
   initial begin
      #2_000_000;
      $display("** bounding_volume_query_unit: FAILED **");
      $finish;
   end

   // receiver side: random back-pressure bursts
   initial begin
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // uniform pick in 0..limit, limit clamped to what $urandom_range can take
   function automatic longint pick_upto(input longint limit);
      if (limit <= 0) return 0;
      if (limit > SPAN_MAX) limit = SPAN_MAX;
      return longint'($urandom_range(32'(limit)));
   endfunction

   function automatic query_item_type build_query(
      input logic [REQ_TYPE_WIDTH-1:0] kind,
      input logic                      sphere,
      input longint                    cx, cy, cz, hx, hy, hz, r
   );
      query_item_type q;
      q.kind   = kind;
      q.sphere = sphere;
      q.cx     = 32'(cx);
      q.cy     = 32'(cy);
      q.cz     = 32'(cz);
      q.hx     = 31'(hx);
      q.hy     = 31'(hy);
      q.hz     = 31'(hz);
      q.radius = 31'(r);
      return q;
   endfunction

   // random query aimed at the current box: mostly same, inside, enclosing,
   // face-touching or nearby volumes, the rest is raw noise
   function automatic query_item_type make_query();
      query_item_type q;
      logic [31:0] cen [3];
      logic [30:0] hal [3];
      longint c, h, r, scale, room;
      int plan, sel, touch_axis, nudge_axis;
      q.kind   = 2'($urandom);
      q.sphere = 1'($urandom);
      q.radius = 31'($urandom);
      for (int i = 0; i < 3; i++) begin
         cen[i] = $urandom;
         hal[i] = 31'($urandom);
      end
      plan = $urandom_range(0, 9);
      if (plan != 0) begin
         sel = $urandom_range(0, 19);
         if (sel == 0) q.kind = REQ_SPARE;
         else if (sel < 7) q.kind = REQ_ENCLOSES;
         else if (sel < 13) q.kind = REQ_ENCLOSED;
         else q.kind = REQ_OVERLAP;
         r = 0;
         if (q.sphere) begin
            case ($urandom_range(0, 3))
               0: r = 0;
               1: r = pick_upto(box_h[0] + box_h[1] + 16);
               2: r = pick_upto(longint'(1) << $urandom_range(0, 31));
               default: r = longint'(q.radius);
            endcase
            if (r > HALF_MAX) r = HALF_MAX;
            q.radius = 31'(r);
         end
         touch_axis = $urandom_range(0, 2);
         for (int i = 0; i < 3; i++) begin
            scale = (box_h[i] > 0) ? box_h[i] : (longint'(1) << $urandom_range(0, 20));
            c = box_c[i];
            case (plan)
               1, 2:    h = box_h[i];
               3, 4:    h = pick_upto(box_h[i]);
               5, 6:    h = box_h[i] + pick_upto(scale);
               7:       h = pick_upto(scale);
               default: h = pick_upto(2 * scale);
            endcase
            if (h > HALF_MAX) h = HALF_MAX;
            if (q.sphere) h = r;
            case (plan)
               3, 4: begin
                  room = box_h[i] - h;
                  if (room < 0) room = 0;
                  c = box_c[i] + pick_upto(2 * room) - room;
               end
               5, 6: begin
                  room = h - box_h[i];
                  if (room < 0) room = 0;
                  c = box_c[i] + pick_upto(2 * room) - room;
               end
               7: begin
                  // faces meet exactly on one axis, gap equals the summed extents
                  if (i == touch_axis)
                     c = box_c[i] + ($urandom_range(0, 1) ? (box_h[i] + h) : -(box_h[i] + h));
               end
               8, 9: c = box_c[i] + pick_upto(4 * scale) - 2 * scale;
               default: ;
            endcase
            cen[i] = 32'(c);
            if (!q.sphere) hal[i] = 31'(h);
         end
         // one lsb off a boundary now and then
         if ($urandom_range(0, 3) == 0) begin
            nudge_axis = $urandom_range(0, 2);
            cen[nudge_axis] = cen[nudge_axis] + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
         end
      end
      q.cx = cen[0];
      q.cy = cen[1];
      q.cz = cen[2];
      q.hx = hal[0];
      q.hy = hal[1];
      q.hz = hal[2];
      return q;
   endfunction

   // called on a rising-edge step, returns after the accepting edge and any random idle gap
   task automatic send_query(input query_item_type q);
      req_valid           <= 1'b1;
      req_type            <= q.kind;
      req_other_is_sphere <= q.sphere;
      req_other_center_x  <= q.cx;
      req_other_center_y  <= q.cy;
      req_other_center_z  <= q.cz;
      req_other_half_x    <= q.hx;
      req_other_half_y    <= q.hy;
      req_other_half_z    <= q.hz;
      req_other_radius    <= q.radius;
      // ready is looked at mid-cycle, so the edge after it is the accepting one
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      if (q.kind == REQ_SPARE) sent_spare++;
      if (q.sphere) sent_sphere++;
      else sent_box++;
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // stop sending and let every outstanding result drain out
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
   endtask

   task automatic write_box(input logic [31:0] cx, cy, cz, hx, hy, hz);
      write_reg(CSR_SELF_CENTER_X, cx);
      write_reg(CSR_SELF_CENTER_Y, cy);
      write_reg(CSR_SELF_CENTER_Z, cz);
      write_reg(CSR_SELF_HALF_X, hx);
      write_reg(CSR_SELF_HALF_Y, hy);
      write_reg(CSR_SELF_HALF_Z, hz);
      csr_write_en <= 1'b0;
      box_c[0] = longint'($signed(cx));
      box_c[1] = longint'($signed(cy));
      box_c[2] = longint'($signed(cz));
      box_h[0] = longint'(hx[30:0]);
      box_h[1] = longint'(hy[30:0]);
      box_h[2] = longint'(hz[30:0]);
      settings++;
   endtask

   initial begin : stimulus
      logic [31:0] cfg [6];
      // everything known from time zero, reset held high at the start
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_type            <= REQ_OVERLAP;
      req_other_is_sphere <= 1'b0;
      req_other_center_x  <= '0;
      req_other_center_y  <= '0;
      req_other_center_z  <= '0;
      req_other_half_x    <= '0;
      req_other_half_y    <= '0;
      req_other_half_z    <= '0;
      req_other_radius    <= '0;
      csr_write_en        <= 1'b0;
      csr_index           <= CSR_SELF_CENTER_X;
      csr_wdata           <= '0;
      gap_pct   = 20;
      stall_pct = 5;
      for (int i = 0; i < 3; i++) begin
         box_c[i] = 0;
         box_h[i] = 0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // the box out of reset is a single point at the origin
      send_query(build_query(REQ_OVERLAP, 1'b0, 0, 0, 0, 0, 0, 0, 0));
      send_query(build_query(REQ_ENCLOSES, 1'b1, 0, 0, 0, 0, 0, 0, 0));
      send_query(build_query(REQ_SPARE, 1'b1, -ONE, ONE, 0, 0, 0, 0, ONE));
      wait_idle();

      // box centered at (5, -3, 1.5) with half extents (2, 1, 4)
      write_box(32'(5 * ONE), 32'(-3 * ONE), 32'(3 * ONE / 2),
                32'(2 * ONE), 32'(ONE), 32'(4 * ONE));
      // identical box under each relation, equal faces count as contained
      send_query(build_query(REQ_OVERLAP, 1'b0, 5*ONE, -3*ONE, 3*ONE/2, 2*ONE, ONE, 4*ONE, 0));
      send_query(build_query(REQ_ENCLOSES, 1'b0, 5*ONE, -3*ONE, 3*ONE/2, 2*ONE, ONE, 4*ONE, 0));
      send_query(build_query(REQ_ENCLOSED, 1'b0, 5*ONE, -3*ONE, 3*ONE/2, 2*ONE, ONE, 4*ONE, 0));
      // boxes whose x faces just touch, then one lsb apart
      send_query(build_query(REQ_OVERLAP, 1'b0, 8*ONE, -3*ONE, 3*ONE/2, ONE, ONE, ONE, 0));
      send_query(build_query(REQ_OVERLAP, 1'b0, 8*ONE + 1, -3*ONE, 3*ONE/2, ONE, ONE, ONE, 0));
      // sphere surface on the x face, then one lsb beyond
      send_query(build_query(REQ_OVERLAP, 1'b1, 15*ONE/2, -3*ONE, 3*ONE/2, 0, 0, 0, ONE/2));
      send_query(build_query(REQ_OVERLAP, 1'b1, 15*ONE/2 + 1, -3*ONE, 3*ONE/2, 0, 0, 0, ONE/2));
      // small sphere inside, big sphere around, small sphere cannot enclose
      send_query(build_query(REQ_ENCLOSES, 1'b1, 5*ONE, -3*ONE, 3*ONE/2, 0, 0, 0, ONE/2));
      send_query(build_query(REQ_ENCLOSED, 1'b1, 5*ONE, -3*ONE, 3*ONE/2, 0, 0, 0, 10*ONE));
      send_query(build_query(REQ_ENCLOSED, 1'b1, 5*ONE, -3*ONE, 3*ONE/2, 0, 0, 0, ONE/2));
      // sphere off a corner, distance on all three axes
      send_query(build_query(REQ_OVERLAP, 1'b1, 8*ONE, -5*ONE, 13*ONE/2, 0, 0, 0, 7*ONE/4));
      // unused code still reports the sphere distance
      send_query(build_query(REQ_SPARE, 1'b1, 100*ONE, 0, 0, 0, 0, 0, ONE));
      // field extremes
      send_query(build_query(REQ_OVERLAP, 1'b0, MAXC, MAXC, MAXC,
                             HALF_MAX, HALF_MAX, HALF_MAX, HALF_MAX));
      send_query(build_query(REQ_ENCLOSED, 1'b0, MINC, MINC, MINC, 0, 0, 0, 0));
      send_query(build_query(REQ_OVERLAP, 1'b1, MINC, MINC, MINC, 0, 0, 0, HALF_MAX));
      send_query(build_query(REQ_OVERLAP, 1'b1, 5*ONE, -3*ONE, 3*ONE/2, 0, 0, 0, 0));
      send_query(build_query(REQ_ENCLOSES, 1'b0, 5*ONE, -3*ONE, 3*ONE/2, 0, 0, 0, 0));
      send_query(build_query(REQ_ENCLOSED, 1'b1, 0, 0, 0,
                             HALF_MAX, HALF_MAX, HALF_MAX, HALF_MAX));
      send_query(build_query(REQ_ENCLOSES, 1'b0, 5*ONE, -3*ONE, 3*ONE/2,
                             2*ONE, ONE, 4*ONE + 1, 0));

      // random phases, each under its own box and idling mix
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         for (int i = 0; i < 3; i++) begin
            cfg[i]     = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
            cfg[i + 3] = $urandom_range(0, 32'h0010_0000);
         end
         case (phase)
            0: begin
               gap_pct   = 25;
               stall_pct = 6;
            end
            1: begin
               // far corner, zero size: sphere distances saturate
               for (int i = 0; i < 3; i++) begin
                  cfg[i]     = 32'h7FFF_FFFF;
                  cfg[i + 3] = 32'h0;
               end
               gap_pct   = 0;
               stall_pct = 10;
            end
            2: begin
               // most negative center, largest halves (bit 31 of the data is dropped)
               for (int i = 0; i < 3; i++) begin
                  cfg[i]     = 32'h8000_0000;
                  cfg[i + 3] = 32'hFFFF_FFFF;
               end
               gap_pct   = 30;
               stall_pct = 0;
            end
            3: begin
               write_reg(CSR_UNMAPPED_LO, $urandom);
               write_reg(CSR_UNMAPPED_HI, $urandom);
               for (int i = 0; i < 6; i++) cfg[i] = $urandom;
               gap_pct   = 15;
               stall_pct = 4;
            end
            4: begin
               // flat box along one axis
               cfg[3 + $urandom_range(0, 2)] = 32'h0;
               gap_pct   = 40;
               stall_pct = 12;
            end
            default: begin
               // closing stretch runs back to back
               gap_pct   = 0;
               stall_pct = 0;
            end
         endcase
         write_box(cfg[0], cfg[1], cfg[2], cfg[3], cfg[4], cfg[5]);
         repeat (RANDOM_PER_PHASE) send_query(make_query());
      end

      wait_idle();
      // room for any stray result behind the last one
      repeat (NUM_STAGES + 4) @(posedge clock);

      $display("covered %0d transactions over %0d box settings:",
               sent_sphere + sent_box, settings);
      $display("  %0d sphere, %0d box, %0d unused code",
               sent_sphere, sent_box, sent_spare);
      $display("checked %0d results, %0d true answers, %0d saturated distances",
               checked, true_answers, saturated);
      if (failures == 0 && pending == 0)
         $display("** bounding_volume_query_unit: PASSED **");
      else
         $display("** bounding_volume_query_unit: FAILED **");
      $finish;
   end

endmodule
